FILE: rtl/bnr_pkg.sv
// Shared types, constants and saturating arithmetic for the Bezier Newton step.
package bnr_pkg;

    typedef logic signed [63:0] t_s64;
    typedef logic signed [31:0] t_s32;
    typedef logic [2:0]         t_reg_idx;

    localparam int NUM_REGS = 8;
    localparam int IDX_W    = 4;

    localparam t_reg_idx REG_P0_X = 3'd0;
    localparam t_reg_idx REG_P0_Y = 3'd1;
    localparam t_reg_idx REG_P1_X = 3'd2;
    localparam t_reg_idx REG_P1_Y = 3'd3;
    localparam t_reg_idx REG_P2_X = 3'd4;
    localparam t_reg_idx REG_P2_Y = 3'd5;
    localparam t_reg_idx REG_P3_X = 3'd6;
    localparam t_reg_idx REG_P3_Y = 3'd7;

    localparam t_s64 MAXV     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_s64 SCALE_D1 = 64'sd3;
    localparam t_s64 SCALE_D2 = 64'sd2;

    localparam int MAG_W    = 63;
    localparam int FRAC_U   = 28;
    localparam int FRAC_C   = 16;
    localparam int DIV_BITS = 40;
    localparam int NL_W     = DIV_BITS - FRAC_U;
    localparam int RES_W    = 43;

    localparam int MUL_LAT  = 4;
    localparam int LERP_LAT = MUL_LAT + 2;
    localparam int AXIS_LAT = 3 * LERP_LAT;
    localparam int PIPE_LAT = AXIS_LAT + 1 + MUL_LAT + 4 + DIV_BITS + 1;

    function automatic t_s64 sat_add(t_s64 a, t_s64 b);
        logic signed [64:0] s;
        logic signed [64:0] smax;
        smax = {MAXV[63], MAXV};
        s    = {a[63], a} + {b[63], b};
        if (s > smax) begin
            return MAXV;
        end else if (s < -smax) begin
            return -MAXV;
        end
        return s[63:0];
    endfunction

    function automatic t_s64 sat_sub(t_s64 a, t_s64 b);
        return sat_add(a, -b);
    endfunction

    function automatic logic [MAG_W-1:0] mag(t_s64 a);
        t_s64 m;
        m = a[63] ? -a : a;
        return m[MAG_W-1:0];
    endfunction

endpackage

FILE: rtl/bnr_delay.sv
// Enabled shift-register delay line for payload.
module bnr_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_sr [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_q = r_sr[N-1];

endmodule

FILE: rtl/bnr_mulshift.sv
// Pipelined saturating multiply with rounded right shift, built from four partial products of up to 32x32 bits.
module bnr_mulshift #(
    parameter int SHIFT = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  bnr_pkg::t_s64 i_a,
    input  bnr_pkg::t_s64 i_b,
    output bnr_pkg::t_s64 o_y
);

    localparam int PW = 127;
    localparam logic [PW-1:0] ROUND = PW'(1) << (SHIFT - 1);

    logic [bnr_pkg::MAG_W-1:0] r_x, r_y;
    logic                      r_neg1, r_neg2, r_neg3;
    logic [63:0]               r_p0;
    logic [62:0]               r_p1, r_p2;
    logic [61:0]               r_p3;
    logic [PW-1:0]             r_prod;
    bnr_pkg::t_s64             r_y_out;

    logic [PW-1:0]             w_sum;
    logic [PW-1:0]             w_sh;
    logic [bnr_pkg::MAG_W-1:0] w_m;

    assign w_sum = PW'(r_p0) + (PW'(r_p1) << 32) + (PW'(r_p2) << 32)
                 + (PW'(r_p3) << 64) + ROUND;
    assign w_sh  = r_prod >> SHIFT;
    assign w_m   = (|w_sh[PW-1:bnr_pkg::MAG_W]) ? bnr_pkg::MAXV[bnr_pkg::MAG_W-1:0]
                                                : w_sh[bnr_pkg::MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x     <= bnr_pkg::mag(i_a);
            r_y     <= bnr_pkg::mag(i_b);
            r_neg1  <= i_a[63] ^ i_b[63];
            r_p0    <= r_x[31:0] * r_y[31:0];
            r_p1    <= r_x[31:0] * r_y[62:32];
            r_p2    <= r_x[62:32] * r_y[31:0];
            r_p3    <= r_x[62:32] * r_y[62:32];
            r_neg2  <= r_neg1;
            r_prod  <= w_sum;
            r_neg3  <= r_neg2;
            r_y_out <= r_neg3 ? -bnr_pkg::t_s64'({1'b0, w_m}) : bnr_pkg::t_s64'({1'b0, w_m});
        end
    end

    assign o_y = r_y_out;

endmodule

FILE: rtl/bnr_lerp.sv
// Pipelined saturating interpolation a + (b - a) * u, u in Q4.28.
module bnr_lerp (
    input  logic          i_clk,
    input  logic          i_en,
    input  bnr_pkg::t_s64 i_a,
    input  bnr_pkg::t_s64 i_b,
    input  bnr_pkg::t_s32 i_u,
    output bnr_pkg::t_s64 o_y
);

    bnr_pkg::t_s64 r_diff, r_a, r_y;
    bnr_pkg::t_s32 r_u;
    bnr_pkg::t_s64 w_m, w_a;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= bnr_pkg::sat_sub(i_b, i_a);
            r_a    <= i_a;
            r_u    <= i_u;
            r_y    <= bnr_pkg::sat_add(w_a, w_m);
        end
    end

    bnr_mulshift #(.SHIFT(bnr_pkg::FRAC_U)) u_mul (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (r_diff),
        .i_b   (bnr_pkg::t_s64'(r_u)),
        .o_y   (w_m)
    );

    bnr_delay #(.W(64), .N(bnr_pkg::MUL_LAT)) u_dly_a (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (r_a),
        .o_q   (w_a)
    );

    assign o_y = r_y;

endmodule

FILE: rtl/bnr_axis.sv
// One coordinate axis: curve value and first and second derivatives by de Casteljau.
module bnr_axis (
    input  logic          i_clk,
    input  logic          i_en,
    input  bnr_pkg::t_s32 i_c0,
    input  bnr_pkg::t_s32 i_c1,
    input  bnr_pkg::t_s32 i_c2,
    input  bnr_pkg::t_s32 i_c3,
    input  bnr_pkg::t_s32 i_u,
    output bnr_pkg::t_s64 o_q,
    output bnr_pkg::t_s64 o_d1,
    output bnr_pkg::t_s64 o_d2
);

    bnr_pkg::t_s64 w_c0, w_c1, w_c2, w_c3;
    bnr_pkg::t_s64 w_g0, w_g1, w_g2, w_r0, w_r1;
    bnr_pkg::t_s64 w_a, w_b, w_e, w_h0, w_h1, w_d2;
    bnr_pkg::t_s64 w_m0, w_m1, w_d1;
    bnr_pkg::t_s32 w_u6, w_u12;

    // control values must stay static while items flow; this block does not enforce it
    assign w_c0 = bnr_pkg::t_s64'(i_c0);
    assign w_c1 = bnr_pkg::t_s64'(i_c1);
    assign w_c2 = bnr_pkg::t_s64'(i_c2);
    assign w_c3 = bnr_pkg::t_s64'(i_c3);
    assign w_g0 = (w_c1 - w_c0) * bnr_pkg::SCALE_D1;
    assign w_g1 = (w_c2 - w_c1) * bnr_pkg::SCALE_D1;
    assign w_g2 = (w_c3 - w_c2) * bnr_pkg::SCALE_D1;
    assign w_r0 = (w_g1 - w_g0) * bnr_pkg::SCALE_D2;
    assign w_r1 = (w_g2 - w_g1) * bnr_pkg::SCALE_D2;

    bnr_lerp u_l1a (.i_clk(i_clk), .i_en(i_en), .i_a(w_c0), .i_b(w_c1), .i_u(i_u), .o_y(w_a));
    bnr_lerp u_l1b (.i_clk(i_clk), .i_en(i_en), .i_a(w_c1), .i_b(w_c2), .i_u(i_u), .o_y(w_b));
    bnr_lerp u_l1e (.i_clk(i_clk), .i_en(i_en), .i_a(w_c2), .i_b(w_c3), .i_u(i_u), .o_y(w_e));
    bnr_lerp u_l1h0 (.i_clk(i_clk), .i_en(i_en), .i_a(w_g0), .i_b(w_g1), .i_u(i_u), .o_y(w_h0));
    bnr_lerp u_l1h1 (.i_clk(i_clk), .i_en(i_en), .i_a(w_g1), .i_b(w_g2), .i_u(i_u), .o_y(w_h1));
    bnr_lerp u_l1d2 (.i_clk(i_clk), .i_en(i_en), .i_a(w_r0), .i_b(w_r1), .i_u(i_u), .o_y(w_d2));

    bnr_delay #(.W(32), .N(bnr_pkg::LERP_LAT)) u_dly_u6 (
        .i_clk(i_clk), .i_en(i_en), .i_d(i_u), .o_q(w_u6)
    );

    bnr_lerp u_l2m0 (.i_clk(i_clk), .i_en(i_en), .i_a(w_a), .i_b(w_b), .i_u(w_u6), .o_y(w_m0));
    bnr_lerp u_l2m1 (.i_clk(i_clk), .i_en(i_en), .i_a(w_b), .i_b(w_e), .i_u(w_u6), .o_y(w_m1));
    bnr_lerp u_l2d1 (.i_clk(i_clk), .i_en(i_en), .i_a(w_h0), .i_b(w_h1), .i_u(w_u6), .o_y(w_d1));

    bnr_delay #(.W(32), .N(bnr_pkg::LERP_LAT)) u_dly_u12 (
        .i_clk(i_clk), .i_en(i_en), .i_d(w_u6), .o_q(w_u12)
    );

    bnr_lerp u_l3q (.i_clk(i_clk), .i_en(i_en), .i_a(w_m0), .i_b(w_m1), .i_u(w_u12), .o_y(o_q));

    bnr_delay #(.W(64), .N(bnr_pkg::LERP_LAT)) u_dly_d1 (
        .i_clk(i_clk), .i_en(i_en), .i_d(w_d1), .o_q(o_d1)
    );

    bnr_delay #(.W(64), .N(2 * bnr_pkg::LERP_LAT)) u_dly_d2 (
        .i_clk(i_clk), .i_en(i_en), .i_d(w_d2), .o_q(o_d2)
    );

endmodule

FILE: rtl/bnr_divide.sv
// Pipelined restoring divider, one quotient bit per stage.
module bnr_divide #(
    parameter int SIDE_W = 1
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [bnr_pkg::MAG_W-1:0]    i_rem,
    input  logic [bnr_pkg::NL_W-1:0]     i_nl,
    input  logic [bnr_pkg::MAG_W-1:0]    i_d,
    input  logic [SIDE_W-1:0]            i_side,
    output logic [bnr_pkg::DIV_BITS-1:0] o_q,
    output logic [SIDE_W-1:0]            o_side
);

    localparam int NB = bnr_pkg::DIV_BITS;
    localparam int MW = bnr_pkg::MAG_W;

    logic [MW-1:0]           r_rem  [NB];
    logic [MW-1:0]           r_d    [NB];
    logic [bnr_pkg::NL_W-1:0] r_nl  [NB];
    logic [NB-1:0]           r_q    [NB];
    logic [SIDE_W-1:0]       r_side [NB];

    for (genvar k = 0; k < NB; k++) begin : g_step
        logic [MW-1:0]            w_rem_in, w_d_in;
        logic [bnr_pkg::NL_W-1:0] w_nl_in;
        logic [NB-1:0]            w_q_in;
        logic [SIDE_W-1:0]        w_side_in;
        logic                     w_bit, w_ge;
        logic [MW:0]              w_sh, w_diff;

        if (k == 0) begin : g_first
            assign w_rem_in  = i_rem;
            assign w_d_in    = i_d;
            assign w_nl_in   = i_nl;
            assign w_q_in    = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_d_in    = r_d[k-1];
            assign w_nl_in   = r_nl[k-1];
            assign w_q_in    = r_q[k-1];
            assign w_side_in = r_side[k-1];
        end

        if (NB - 1 - k >= bnr_pkg::FRAC_U) begin : g_num
            assign w_bit = w_nl_in[NB - 1 - k - bnr_pkg::FRAC_U];
        end else begin : g_zero
            assign w_bit = 1'b0;
        end

        assign w_sh   = {w_rem_in, w_bit};
        assign w_ge   = (w_sh >= {1'b0, w_d_in});
        assign w_diff = w_sh - {1'b0, w_d_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_diff[MW-1:0] : w_sh[MW-1:0];
                r_q[k]    <= {w_q_in[NB-2:0], w_ge};
                r_d[k]    <= w_d_in;
                r_nl[k]   <= w_nl_in;
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_q    = r_q[NB-1];
    assign o_side = r_side[NB-1];

endmodule

FILE: rtl/bezier_newton_reparameterize_top.sv
// Top level: config registers, curve evaluation, error and dot-product stages, divide and output register.
// One Newton reparameterisation step per point against a cubic Bezier held in eight
// Q16.16 control registers. A new point (Q16.16 x, y and Q4.28 u) is taken every
// clock while the output is not stalled; each result comes from de Casteljau
// evaluation (three interpolation levels), the dot-product and denominator stages,
// and a 40-stage one-bit-per-stage divider. A stalled output holds the whole
// pipeline, so nothing is lost or repeated. The config port is
// always ready; control points must only be written while no item is in flight.
module bezier_newton_reparameterize_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [95:0]                i_s_axis_tdata,  // point_x, point_y, param_u
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [31:0]                o_m_axis_tdata,  // new_param_u
    output logic [1:0]                 o_m_axis_tuser,  // denominator_zero, saturated
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [bnr_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                i_cfg_data
);

    localparam int LAT = bnr_pkg::PIPE_LAT;
    localparam int MW  = bnr_pkg::MAG_W;
    localparam int RW  = bnr_pkg::RES_W;
    localparam int SW  = 32 + 3;
    localparam logic signed [RW-1:0] RES_MAX = RW'(64'sd2147483647);
    localparam logic signed [RW-1:0] RES_MIN = -RW'(64'sd2147483648);
    localparam logic [bnr_pkg::DIV_BITS:0] CAP_Q = {1'b1, {bnr_pkg::DIV_BITS{1'b0}}};

    bnr_pkg::t_s32 r_ctrl [bnr_pkg::NUM_REGS];
    logic [LAT-1:0] r_vld;
    logic           w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < bnr_pkg::NUM_REGS; k++) begin
                r_ctrl[k] <= '0;
            end
        end else if (i_cfg_valid && (i_cfg_index < bnr_pkg::IDX_W'(bnr_pkg::NUM_REGS))) begin
            r_ctrl[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign w_en            = ~r_vld[LAT-1] | i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    // curve evaluation
    bnr_pkg::t_s32 w_px, w_py, w_u;
    bnr_pkg::t_s64 w_qx, w_qy, w_d1x, w_d1y, w_d2x, w_d2y;
    logic [63:0]   w_p_dly;
    bnr_pkg::t_s32 w_u_ax;

    assign w_px = i_s_axis_tdata[31:0];
    assign w_py = i_s_axis_tdata[63:32];
    assign w_u  = i_s_axis_tdata[95:64];

    bnr_axis u_axis_x (
        .i_clk(i_clk), .i_en(w_en),
        .i_c0(r_ctrl[bnr_pkg::REG_P0_X]), .i_c1(r_ctrl[bnr_pkg::REG_P1_X]),
        .i_c2(r_ctrl[bnr_pkg::REG_P2_X]), .i_c3(r_ctrl[bnr_pkg::REG_P3_X]),
        .i_u(w_u), .o_q(w_qx), .o_d1(w_d1x), .o_d2(w_d2x)
    );

    bnr_axis u_axis_y (
        .i_clk(i_clk), .i_en(w_en),
        .i_c0(r_ctrl[bnr_pkg::REG_P0_Y]), .i_c1(r_ctrl[bnr_pkg::REG_P1_Y]),
        .i_c2(r_ctrl[bnr_pkg::REG_P2_Y]), .i_c3(r_ctrl[bnr_pkg::REG_P3_Y]),
        .i_u(w_u), .o_q(w_qy), .o_d1(w_d1y), .o_d2(w_d2y)
    );

    bnr_delay #(.W(64), .N(bnr_pkg::AXIS_LAT)) u_dly_p (
        .i_clk(i_clk), .i_en(w_en), .i_d({w_py, w_px}), .o_q(w_p_dly)
    );

    bnr_delay #(.W(32), .N(bnr_pkg::AXIS_LAT)) u_dly_u_ax (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_u), .o_q(w_u_ax)
    );

    // error vector
    bnr_pkg::t_s64 r_ex, r_ey, r_d1x, r_d1y, r_d2x, r_d2y;
    bnr_pkg::t_s32 r_u_e;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ex  <= bnr_pkg::sat_sub(w_qx, bnr_pkg::t_s64'(bnr_pkg::t_s32'(w_p_dly[31:0])));
            r_ey  <= bnr_pkg::sat_sub(w_qy, bnr_pkg::t_s64'(bnr_pkg::t_s32'(w_p_dly[63:32])));
            r_d1x <= w_d1x;
            r_d1y <= w_d1y;
            r_d2x <= w_d2x;
            r_d2y <= w_d2y;
            r_u_e <= w_u_ax;
        end
    end

    // dot-product terms
    bnr_pkg::t_s64 w_t0, w_t1, w_t2, w_t3, w_t4, w_t5;
    bnr_pkg::t_s32 w_u_m;

    bnr_mulshift #(.SHIFT(bnr_pkg::FRAC_C)) u_m0 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_ex), .i_b(r_d1x), .o_y(w_t0));
    bnr_mulshift #(.SHIFT(bnr_pkg::FRAC_C)) u_m1 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_ey), .i_b(r_d1y), .o_y(w_t1));
    bnr_mulshift #(.SHIFT(bnr_pkg::FRAC_C)) u_m2 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_d1x), .i_b(r_d1x), .o_y(w_t2));
    bnr_mulshift #(.SHIFT(bnr_pkg::FRAC_C)) u_m3 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_d1y), .i_b(r_d1y), .o_y(w_t3));
    bnr_mulshift #(.SHIFT(bnr_pkg::FRAC_C)) u_m4 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_ex), .i_b(r_d2x), .o_y(w_t4));
    bnr_mulshift #(.SHIFT(bnr_pkg::FRAC_C)) u_m5 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_ey), .i_b(r_d2y), .o_y(w_t5));

    bnr_delay #(.W(32), .N(bnr_pkg::MUL_LAT)) u_dly_u_m (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_u_e), .o_q(w_u_m)
    );

    // numerator, denominator, magnitudes, cap test
    bnr_pkg::t_s64            r_num, r_s1, r_s2, r_num2, r_den;
    bnr_pkg::t_s32            r_u_s, r_u_d, r_u_g, r_u_c;
    logic [MW-1:0]            r_n, r_d, r_r0, r_dv;
    logic                     r_dz, r_negq, r_dz_c, r_negq_c, r_cap;
    logic [bnr_pkg::NL_W-1:0] r_nl;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num    <= bnr_pkg::sat_add(w_t0, w_t1);
            r_s1     <= bnr_pkg::sat_add(w_t2, w_t3);
            r_s2     <= bnr_pkg::sat_add(w_t4, w_t5);
            r_u_s    <= w_u_m;
            r_num2   <= r_num;
            r_den    <= bnr_pkg::sat_add(r_s1, r_s2);
            r_u_d    <= r_u_s;
            r_n      <= bnr_pkg::mag(r_num2);
            r_d      <= bnr_pkg::mag(r_den);
            r_dz     <= (r_den == '0);
            r_negq   <= r_num2[63] ^ r_den[63];
            r_u_g    <= r_u_d;
            r_cap    <= ({{bnr_pkg::NL_W{1'b0}}, r_n} >= {r_d, {bnr_pkg::NL_W{1'b0}}});
            r_r0     <= {{bnr_pkg::NL_W{1'b0}}, r_n[MW-1:bnr_pkg::NL_W]};
            r_nl     <= r_n[bnr_pkg::NL_W-1:0];
            r_dv     <= r_d;
            r_dz_c   <= r_dz;
            r_negq_c <= r_negq;
            r_u_c    <= r_u_g;
        end
    end

    // quotient
    logic [bnr_pkg::DIV_BITS-1:0] w_quo;
    logic [SW-1:0]                w_side;

    bnr_divide #(.SIDE_W(SW)) u_div (
        .i_clk(i_clk), .i_en(w_en),
        .i_rem(r_r0), .i_nl(r_nl), .i_d(r_dv),
        .i_side({r_u_c, r_dz_c, r_negq_c, r_cap}),
        .o_q(w_quo), .o_side(w_side)
    );

    // update and clip
    bnr_pkg::t_s32              w_u_f;
    logic                       w_dz_f, w_negq_f, w_cap_f, w_hi, w_lo;
    logic [bnr_pkg::DIV_BITS:0] w_step;
    logic signed [RW-1:0]       w_res;
    logic [31:0]                r_out_data;
    logic                       r_out_dz, r_out_sat;

    assign w_u_f    = w_side[SW-1:3];
    assign w_dz_f   = w_side[2];
    assign w_negq_f = w_side[1];
    assign w_cap_f  = w_side[0];
    assign w_step   = w_cap_f ? CAP_Q : {1'b0, w_quo};
    assign w_res    = w_negq_f ? (RW'(w_u_f) + $signed(RW'(w_step)))
                               : (RW'(w_u_f) - $signed(RW'(w_step)));
    assign w_hi     = (w_res > RES_MAX);
    assign w_lo     = (w_res < RES_MIN);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_dz_f) begin
                r_out_data <= w_u_f;
                r_out_dz   <= 1'b1;
                r_out_sat  <= 1'b0;
            end else begin
                r_out_data <= w_hi ? RES_MAX[31:0] : (w_lo ? RES_MIN[31:0] : w_res[31:0]);
                r_out_dz   <= 1'b0;
                r_out_sat  <= w_hi | w_lo;
            end
        end
    end

    assign o_m_axis_tdata = r_out_data;
    assign o_m_axis_tuser = {r_out_sat, r_out_dz};

    a_flags_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("zero denominator and saturation flagged together");

    a_stall_freezes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_transfer_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted item did not enter the pipeline");

    a_sat_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |->
        (o_m_axis_tdata == 32'h7FFF_FFFF || o_m_axis_tdata == 32'h8000_0000))
        else $error("saturated result is not a range bound");

endmodule

FILE: test/tb_bezier_newton_reparameterize_top.sv
// Bezier Newton reparameterisation testbench: directed and random stream traffic against a bit-exact predictor.
module tb_bezier_newton_reparameterize_top;

    typedef struct packed {
        logic [31:0] param_u;
        logic [31:0] point_y;
        logic [31:0] point_x;
    } t_point;

    typedef struct packed {
        logic [31:0] new_u;
        logic        den_zero;
        logic        sat;
    } t_refined;

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] STEP_CAP = 64'd1 << 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [95:0] i_s_axis_tdata = '0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic [1:0] o_m_axis_tuser;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [bnr_pkg::IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    bezier_newton_reparameterize_top i_dut (.*);

    always #1 i_clk = ~i_clk;

    logic [31:0] ctrl_regs [bnr_pkg::NUM_REGS];
    t_point point_queue [$];
    t_refined expected_steps [$];
    int errors = 0;
    bit feed_enable = 1'b0;
    bit hold_off = 1'b0;
    int hold_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;

    // ---- predictor ----
    function automatic longint sadd(longint a, longint b);
        if (b > 0 && a > longint'(SMAX) - b) return longint'(SMAX);
        if (b < 0 && a < -longint'(SMAX) - b) return -longint'(SMAX);
        return a + b;
    endfunction

    function automatic longint mul_round(longint a, longint b, int sh);
        logic [127:0] p;
        logic [63:0] x, y, r;
        x = a < 0 ? -a : a;
        y = b < 0 ? -b : b;
        p = x * y;
        p = (p + (128'd1 << (sh - 1))) >> sh;
        r = (p > {64'd0, SMAX}) ? SMAX : p[63:0];
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint interp(longint a, longint b, longint u);
        return sadd(a, mul_round(sadd(b, -a), u, bnr_pkg::FRAC_U));
    endfunction

    function automatic longint triple_diff(longint a, longint b);
        longint d;
        d = sadd(b, -a);
        return sadd(d, sadd(d, d));
    endfunction

    function automatic void eval_axis(input longint c[4], input longint u,
                                      output longint q, output longint d1,
                                      output longint d2);
        longint a, b, e, g0, g1, g2, r0, r1, t;
        a = interp(c[0], c[1], u);
        b = interp(c[1], c[2], u);
        e = interp(c[2], c[3], u);
        g0 = triple_diff(c[0], c[1]);
        g1 = triple_diff(c[1], c[2]);
        g2 = triple_diff(c[2], c[3]);
        t = sadd(g1, -g0);
        r0 = sadd(t, t);
        t = sadd(g2, -g1);
        r1 = sadd(t, t);
        q = interp(interp(a, b, u), interp(b, e, u), u);
        d1 = interp(interp(g0, g1, u), interp(g1, g2, u), u);
        d2 = interp(r0, r1, u);
    endfunction

    function automatic t_refined newton_step(t_point p);
        longint cx[4], cy[4], qx, qy, d1x, d1y, d2x, d2y, ex, ey, num, den, u, res;
        logic [127:0] quot;
        logic [63:0] nm, dm;
        t_refined r;
        u = longint'(signed'(p.param_u));
        for (int i = 0; i < 4; i++) begin
            cx[i] = longint'(signed'(ctrl_regs[2*i]));
            cy[i] = longint'(signed'(ctrl_regs[2*i+1]));
        end
        eval_axis(cx, u, qx, d1x, d2x);
        eval_axis(cy, u, qy, d1y, d2y);
        ex = sadd(qx, -longint'(signed'(p.point_x)));
        ey = sadd(qy, -longint'(signed'(p.point_y)));
        num = sadd(mul_round(ex, d1x, bnr_pkg::FRAC_C), mul_round(ey, d1y, bnr_pkg::FRAC_C));
        den = sadd(sadd(mul_round(d1x, d1x, bnr_pkg::FRAC_C),
                        mul_round(d1y, d1y, bnr_pkg::FRAC_C)),
                   sadd(mul_round(ex, d2x, bnr_pkg::FRAC_C),
                        mul_round(ey, d2y, bnr_pkg::FRAC_C)));
        if (den == 0) begin
            r.new_u = p.param_u;
            r.den_zero = 1'b1;
            r.sat = 1'b0;
            return r;
        end
        nm = num < 0 ? -num : num;
        dm = den < 0 ? -den : den;
        quot = ({64'd0, nm} << bnr_pkg::FRAC_U) / {64'd0, dm};
        if (quot > {64'd0, STEP_CAP}) quot = {64'd0, STEP_CAP};
        if ((num < 0) != (den < 0)) res = u + longint'(quot[63:0]);
        else res = u - longint'(quot[63:0]);
        r.den_zero = 1'b0;
        r.sat = 1'b0;
        if (res > 64'sh7FFF_FFFF) begin
            res = 64'sh7FFF_FFFF;
            r.sat = 1'b1;
        end
        if (res < -64'sh8000_0000) begin
            res = -64'sh8000_0000;
            r.sat = 1'b1;
        end
        r.new_u = res[31:0];
        return r;
    endfunction

    // ---- driver ----
    always @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            expected_steps = {expected_steps, newton_step(t_point'(i_s_axis_tdata))};
            void'(point_queue.pop_front());
        end
        if (i_s_axis_tvalid && !o_s_axis_tready) begin
        end else if (feed_enable && point_queue.size() > 0 && burst_left > 0) begin
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata <= point_queue[0];
            burst_left <= burst_left - 1;
        end else begin
            i_s_axis_tvalid <= 1'b0;
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else begin
                burst_left <= $urandom_range(1, 40);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
        end
    end

    // ---- receiver stall pattern and monitor ----
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_axis_tready <= 1'b0;
        end else if (hold_off) begin
            hold_cycles <= 300;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 7) < 5) || ($urandom_range(0, 9) == 0);
        end
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_steps.size() == 0) begin
                $error("unexpected transfer: new_param_u %h", o_m_axis_tdata);
                errors++;
            end else begin
                t_refined e;
                e = expected_steps.pop_front();
                if (o_m_axis_tdata !== e.new_u) begin
                    $error("new_param_u exp %h got %h", e.new_u, o_m_axis_tdata);
                    errors++;
                end
                if (o_m_axis_tuser[0] !== e.den_zero) begin
                    $error("denominator_zero exp %b got %b", e.den_zero, o_m_axis_tuser[0]);
                    errors++;
                end
                if (o_m_axis_tuser[1] !== e.sat) begin
                    $error("saturated exp %b got %b", e.sat, o_m_axis_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // ---- stimulus ----
    task automatic write_reg(input bnr_pkg::t_reg_idx idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= bnr_pkg::IDX_W'(idx);
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        ctrl_regs[idx] = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_bad_index();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= bnr_pkg::IDX_W'(bnr_pkg::NUM_REGS + $urandom_range(0, 7));
        i_cfg_data <= $urandom;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        wait (point_queue.size() == 0 && !i_s_axis_tvalid && expected_steps.size() == 0);
        repeat (bnr_pkg::PIPE_LAT + 10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'(signed'($urandom_range(0, 400)) - 200) <<< 16
                            | ($urandom & 32'h0000_FFFF);
        endcase
    endfunction

    function automatic t_point rnd_point(int mode);
        t_point p;
        p.point_x = rnd_coord(mode);
        p.point_y = rnd_coord(mode);
        case ($urandom_range(0, 5))
            0: p.param_u = $urandom;
            1: p.param_u = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: p.param_u = $urandom_range(0, 32'h1000_0000);
        endcase
        return p;
    endfunction

    task automatic load_curve(int mode);
        for (int i = 0; i < bnr_pkg::NUM_REGS; i++) begin
            write_reg(bnr_pkg::t_reg_idx'(i), rnd_coord(mode));
        end
    endtask

    initial begin
        t_point p;
        for (int i = 0; i < bnr_pkg::NUM_REGS; i++) ctrl_regs[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero curve: every denominator is zero
        p = '{point_x: 32'h0, point_y: 32'h0, param_u: 32'h0800_0000};
        point_queue = {point_queue, p};
        p = '{point_x: 32'h7FFF_FFFF, point_y: 32'h8000_0000, param_u: 32'h8000_0000};
        point_queue = {point_queue, p};
        feed_enable = 1'b1;
        drain();
        feed_enable = 1'b0;

        // directed curve at a sensible scale, then extreme and random point values
        write_reg(bnr_pkg::REG_P0_X, 32'h0000_0000);
        write_reg(bnr_pkg::REG_P0_Y, 32'h0000_0000);
        write_reg(bnr_pkg::REG_P1_X, 32'h0001_0000);
        write_reg(bnr_pkg::REG_P1_Y, 32'h0002_0000);
        write_reg(bnr_pkg::REG_P2_X, 32'h0003_0000);
        write_reg(bnr_pkg::REG_P2_Y, 32'h0002_0000);
        write_reg(bnr_pkg::REG_P3_X, 32'h0004_0000);
        write_reg(bnr_pkg::REG_P3_Y, 32'h0000_0000);
        write_bad_index();
        for (int i = 0; i < 20; i++) begin
            p.point_x = (i[0]) ? 32'h7FFF_FFFF : 32'h8000_0000;
            p.point_y = (i[1]) ? 32'h7FFF_FFFF : 32'h0001_8000;
            p.param_u = (i % 5 == 0) ? 32'h7FFF_FFFF : (i % 5 == 1) ? 32'h8000_0000 :
                        (i % 5 == 2) ? 32'h0 : (i % 5 == 3) ? 32'h1000_0000 : 32'h0800_0000;
            if (i >= 12) p = rnd_point(2);
            point_queue = {point_queue, p};
        end
        feed_enable = 1'b1;
        drain();
        feed_enable = 1'b0;

        for (int ph = 0; ph < 11; ph++) begin
            load_curve(ph == 1 ? 1 : ph == 2 ? 0 : 2);
            if (ph == 3) write_bad_index();
            for (int i = 0; i < 100; i++) begin
                point_queue = {point_queue, rnd_point(ph % 4 == 1 ? 0 : 2)};
            end
            feed_enable = 1'b1;
            if (ph == 4) begin
                hold_off = 1'b1;
                wait (hold_cycles > 0);
                hold_off = 1'b0;
            end
            if (ph == 6) begin
                wait (point_queue.size() < 50);
                feed_enable = 1'b0;
                wait (expected_steps.size() == 0 && !i_s_axis_tvalid);
                feed_enable = 1'b1;
            end
            drain();
            feed_enable = 1'b0;
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: bezier_newton_reparameterize_top.f
rtl/bnr_pkg.sv
rtl/bnr_delay.sv
rtl/bnr_mulshift.sv
rtl/bnr_lerp.sv
rtl/bnr_axis.sv
rtl/bnr_divide.sv
rtl/bezier_newton_reparameterize_top.sv
test/tb_bezier_newton_reparameterize_top.sv
